// ===== rtl/core/plant_stress_score_assert.svh =====
// Assertion macros for the stress score block.
// No dependencies; taken in by the modules that check themselves.
`ifndef PLANT_STRESS_SCORE_ASSERT_SVH
`define PLANT_STRESS_SCORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSS_ASSERT(lbl, clk, rstn, prop, msg)
`define PSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pss_pkg.sv =====
// Shared types, register indexes and constant dividers for the stress score block.
// No dependencies.
`default_nettype none
package pss_pkg;

    typedef logic [6:0] part_t;
    typedef part_t parts_t [4];

    localparam logic [2:0] REG_SOIL_BASE  = 3'd0;
    localparam logic [2:0] REG_HEAT_BASE  = 3'd1;
    localparam logic [2:0] REG_HEAT_RANGE = 3'd2;
    localparam logic [2:0] REG_LIGHT_BASE = 3'd3;
    localparam logic [2:0] REG_HUM_BASE   = 3'd4;
    localparam logic [2:0] REG_WEIGHTS    = 3'd5;
    localparam logic [2:0] REG_DOMINANCE  = 3'd6;
    localparam logic [2:0] REG_BASE_SCORE = 3'd7;

    localparam part_t FULL_SCORE = 7'd100;

    // x / 100 for x < 25600
    function automatic logic [7:0] div100_s(input logic [14:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd5243;
        return p[26:19];
    endfunction

    // x / 100 for x < 43699
    function automatic logic [9:0] div100_w(input logic [16:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd41944;
        return p[31:22];
    endfunction

    // x / 3 for x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pss_partial.sv =====
// Four-stage partial score unit: clipped deficit, then 7-bit restoring divide.
// Uses pss_pkg.
`default_nettype none
module pss_partial #(
    parameter int DW = 16
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic          sel,
    input  wire logic [DW:0]   a,
    input  wire logic [DW:0]   b,
    input  wire logic [DW-1:0] dvs,
    output pss_pkg::part_t     partial
);
    import pss_pkg::*;

    localparam int NW = DW + 7;

    logic signed [DW+1:0] diff;
    logic                 pos;
    logic                 full;

    logic          act1_reg, full1_reg;
    logic [DW-1:0] dif1_reg, dvs1_reg;

    logic          act2_reg, full2_reg;
    logic [NW-1:0] num2_reg, den2_reg;
    logic [1:0]    q2_reg;
    logic [NW-1:0] num2_next;
    logic [1:0]    q2_next;

    logic          act3_reg, full3_reg;
    logic [NW-1:0] num3_reg, den3_reg;
    logic [4:0]    q3_reg;
    logic [NW-1:0] num3_next;
    logic [2:0]    q3_next;

    logic [NW-1:0] num4;
    logic [1:0]    q4;
    part_t         part_reg, part_next;

    always_comb begin
        diff = $signed({a[DW], a}) - $signed({b[DW], b});
        pos  = !diff[DW+1] && (diff != '0);
        full = diff >= $signed({2'b00, dvs});
    end

    always_comb begin
        logic [NW-1:0] n;
        logic [NW-1:0] d;
        n = NW'(dif1_reg) * NW'(100);
        d = NW'(dvs1_reg);
        for (int k = 0; k < 2; k++) begin
            if (n >= (d << (6 - k))) begin
                n = n - (d << (6 - k));
                q2_next[1-k] = 1'b1;
            end else begin
                q2_next[1-k] = 1'b0;
            end
        end
        num2_next = n;
    end

    always_comb begin
        logic [NW-1:0] n;
        n = num2_reg;
        for (int k = 0; k < 3; k++) begin
            if (n >= (den2_reg << (4 - k))) begin
                n = n - (den2_reg << (4 - k));
                q3_next[2-k] = 1'b1;
            end else begin
                q3_next[2-k] = 1'b0;
            end
        end
        num3_next = n;
    end

    always_comb begin
        num4 = num3_reg;
        for (int k = 0; k < 2; k++) begin
            if (num4 >= (den3_reg << (1 - k))) begin
                num4 = num4 - (den3_reg << (1 - k));
                q4[1-k] = 1'b1;
            end else begin
                q4[1-k] = 1'b0;
            end
        end
        if (!act3_reg) begin
            part_next = '0;
        end else if (full3_reg) begin
            part_next = FULL_SCORE;
        end else begin
            part_next = {q3_reg, q4};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg  <= sel && pos && (dvs != '0);
            full1_reg <= full;
            dif1_reg  <= diff[DW-1:0];
            dvs1_reg  <= dvs;

            act2_reg  <= act1_reg;
            full2_reg <= full1_reg;
            num2_reg  <= num2_next;
            den2_reg  <= NW'(dvs1_reg);
            q2_reg    <= q2_next;

            act3_reg  <= act2_reg;
            full3_reg <= full2_reg;
            num3_reg  <= num3_next;
            den3_reg  <= den2_reg;
            q3_reg    <= {q2_reg, q3_next};

            part_reg  <= part_next;
        end
    end

    assign partial = part_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pss_combine.sv =====
// Seven-stage combiner: weighting, dominant/secondary blend, base score scaling.
// Uses pss_pkg.
`default_nettype none
module pss_combine (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [3:0]  mask_in,
    input  wire pss_pkg::parts_t parts_in,
    input  wire logic [31:0] weights,
    input  wire logic [6:0]  dominance,
    input  wire logic [7:0]  base,
    output logic             known,
    output logic [6:0]       score,
    output logic [3:0]       mask_out,
    output pss_pkg::parts_t  parts_out
);
    import pss_pkg::*;

    logic [3:0] msk_reg [7];
    parts_t     prt_reg [7];

    logic [7:0] wp1_reg [4];

    logic [7:0] max2_reg, max2_next;
    logic [9:0] oth2_reg, oth2_next;
    logic [2:0] cnt2_reg, cnt2_next;

    logic signed [8:0]  fac;
    logic signed [19:0] prod3_reg;
    logic [7:0]         max3_reg;
    logic [2:0]         cnt3_reg;

    logic [19:0] mag;
    logic [9:0]  q4_reg;
    logic        neg4_reg;
    logic [7:0]  max4_reg;
    logic [2:0]  cnt4_reg;

    logic [9:0]         qc;
    logic signed [11:0] devs;
    logic [6:0]         dev5_reg, dev5_next;
    logic [6:0]         bc5_reg, bc;

    logic [13:0] m6_reg;
    logic [6:0]  bc6_reg;

    logic [7:0]  fin;
    logic [6:0]  score_reg, score_next;

    always_comb begin
        logic [9:0] sum;
        max2_next = '0;
        sum       = '0;
        cnt2_next = '0;
        for (int g = 0; g < 4; g++) begin
            if (wp1_reg[g] > max2_next) begin
                max2_next = wp1_reg[g];
            end
            sum       = sum + 10'(wp1_reg[g]);
            cnt2_next = cnt2_next + 3'(msk_reg[0][g]);
        end
        oth2_next = sum - 10'(max2_next);
    end

    assign fac = 9'sd100 - $signed({2'b00, dominance});
    assign mag = prod3_reg[19] ? 20'(-prod3_reg) : prod3_reg;

    always_comb begin
        unique case (cnt4_reg)
            3'd2:    qc = q4_reg;
            3'd3:    qc = {1'b0, q4_reg[9:1]};
            3'd4:    qc = {2'b00, div3(q4_reg)};
            default: qc = '0;
        endcase
        devs = $signed({4'b0000, max4_reg}) + (neg4_reg ? -$signed({2'b00, qc})
                                                         : $signed({2'b00, qc}));
        priority if (devs > 12'sd100) begin
            dev5_next = 7'd100;
        end else if (devs < 12'sd0) begin
            dev5_next = '0;
        end else begin
            dev5_next = devs[6:0];
        end
        bc = (base > 8'd100) ? 7'd100 : base[6:0];
    end

    always_comb begin
        fin        = 8'(bc6_reg) + div100_s(15'(m6_reg));
        score_next = (fin > 8'd100) ? 7'd100 : fin[6:0];
        if (msk_reg[5] == '0) begin
            score_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            msk_reg[0] <= mask_in;
            prt_reg[0] <= parts_in;
            for (int s = 1; s < 7; s++) begin
                msk_reg[s] <= msk_reg[s-1];
                prt_reg[s] <= prt_reg[s-1];
            end

            for (int g = 0; g < 4; g++) begin
                wp1_reg[g] <= mask_in[g] ? div100_s(15'(parts_in[g]) * 15'(weights[8*g +: 8]))
                                         : 8'd0;
            end

            max2_reg <= max2_next;
            oth2_reg <= oth2_next;
            cnt2_reg <= cnt2_next;

            prod3_reg <= 20'($signed({1'b0, oth2_reg})) * 20'(fac);
            max3_reg  <= max2_reg;
            cnt3_reg  <= cnt2_reg;

            q4_reg   <= div100_w(mag[16:0]);
            neg4_reg <= prod3_reg[19];
            max4_reg <= max3_reg;
            cnt4_reg <= cnt3_reg;

            dev5_reg <= dev5_next;
            bc5_reg  <= bc;

            m6_reg  <= 14'(7'd100 - bc5_reg) * 14'(dev5_reg);
            bc6_reg <= bc5_reg;

            score_reg <= score_next;
        end
    end

    assign known     = msk_reg[6] != '0;
    assign score     = score_reg;
    assign mask_out  = msk_reg[6];
    assign parts_out = prt_reg[6];

endmodule
`default_nettype wire

// ===== rtl/core/plant_stress_score.sv =====
// Top level of the plant stress score block: registers, valid pipeline, units.
// Uses pss_pkg, pss_partial, pss_combine and plant_stress_score_assert.svh.
//
//  channel   ports                          direction
//  s_        sensor word, valid/ready       in
//  m_        score word, valid/ready        out
//  cfg_      index/data, valid/ready        in
//
// The pipeline runs through the partial dividers, then the combiner.
// One word per cycle; every stage holds while m_valid is high and m_ready low.
// s_ready = !m_valid || m_ready; cfg_ready is always high.
// Reset clears the valid pipeline and loads register defaults.
`default_nettype none
module plant_stress_score #(
    parameter int LIGHT_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [9:0]            s_soil_moisture,
    input  wire logic signed [15:0]    s_leaf_air_delta,
    input  wire logic [LIGHT_BITS-1:0] s_illuminance,
    input  wire logic [13:0]           s_humidity,
    input  wire logic [3:0]            s_valid_mask,
    input  wire logic                  s_soil_ok,
    input  wire logic                  s_leaf_ok,
    input  wire logic                  s_air_hum_ok,
    input  wire logic                  s_lux_ok,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_score_known,
    output logic [6:0]                 m_stress_score,
    output logic [3:0]                 m_evaluated_mask,
    output logic [6:0]                 m_soil_partial,
    output logic [6:0]                 m_heat_partial,
    output logic [6:0]                 m_light_partial,
    output logic [6:0]                 m_humidity_partial,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);
    import pss_pkg::*;

    localparam int LAT = 11;
    localparam int PLAT = 4;

    logic [9:0]            soil_base_reg;
    logic signed [15:0]    heat_base_reg;
    logic [14:0]           heat_range_reg;
    logic [LIGHT_BITS-1:0] light_base_reg;
    logic [13:0]           hum_base_reg;
    logic [31:0]           weights_reg;
    logic [6:0]            dom_reg;
    logic [7:0]            base_reg;

    logic [LAT-1:0] vld_reg;
    logic           en;
    logic [3:0]     mask;
    logic [3:0]     msk_reg [PLAT];
    parts_t         parts;
    parts_t         parts_out;

    assign en        = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_comb begin
        mask[0] = s_soil_ok && s_valid_mask[0];
        mask[1] = s_leaf_ok && s_air_hum_ok && s_valid_mask[1];
        mask[2] = s_lux_ok && s_valid_mask[2];
        mask[3] = s_air_hum_ok && s_valid_mask[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soil_base_reg  <= 10'd400;
            heat_base_reg  <= '0;
            heat_range_reg <= 15'd500;
            light_base_reg <= '0;
            hum_base_reg   <= 14'd5000;
            weights_reg    <= 32'h1919_1919;
            dom_reg        <= '0;
            base_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SOIL_BASE:  soil_base_reg  <= cfg_data[9:0];
                REG_HEAT_BASE:  heat_base_reg  <= cfg_data[15:0];
                REG_HEAT_RANGE: heat_range_reg <= cfg_data[14:0];
                REG_LIGHT_BASE: light_base_reg <= cfg_data[LIGHT_BITS-1:0];
                REG_HUM_BASE:   hum_base_reg   <= cfg_data[13:0];
                REG_WEIGHTS:    weights_reg    <= cfg_data;
                REG_DOMINANCE:  dom_reg        <= cfg_data[6:0];
                REG_BASE_SCORE: base_reg       <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            msk_reg[0] <= mask;
            for (int s = 1; s < PLAT; s++) begin
                msk_reg[s] <= msk_reg[s-1];
            end
        end
    end

    pss_partial #(.DW(10)) u_soil (
        .aclk    (aclk),
        .en      (en),
        .sel     (mask[0]),
        .a       ({1'b0, soil_base_reg}),
        .b       ({1'b0, s_soil_moisture}),
        .dvs     (soil_base_reg),
        .partial (parts[0])
    );

    pss_partial #(.DW(16)) u_heat (
        .aclk    (aclk),
        .en      (en),
        .sel     (mask[1]),
        .a       ({s_leaf_air_delta[15], s_leaf_air_delta}),
        .b       ({heat_base_reg[15], heat_base_reg}),
        .dvs     ({1'b0, heat_range_reg}),
        .partial (parts[1])
    );

    pss_partial #(.DW(LIGHT_BITS)) u_light (
        .aclk    (aclk),
        .en      (en),
        .sel     (mask[2]),
        .a       ({1'b0, light_base_reg}),
        .b       ({1'b0, s_illuminance}),
        .dvs     (light_base_reg),
        .partial (parts[2])
    );

    pss_partial #(.DW(14)) u_hum (
        .aclk    (aclk),
        .en      (en),
        .sel     (mask[3]),
        .a       ({1'b0, hum_base_reg}),
        .b       ({1'b0, s_humidity}),
        .dvs     (hum_base_reg),
        .partial (parts[3])
    );

    pss_combine u_comb (
        .aclk      (aclk),
        .en        (en),
        .mask_in   (msk_reg[PLAT-1]),
        .parts_in  (parts),
        .weights   (weights_reg),
        .dominance (dom_reg),
        .base      (base_reg),
        .known     (m_score_known),
        .score     (m_stress_score),
        .mask_out  (m_evaluated_mask),
        .parts_out (parts_out)
    );

    assign m_soil_partial     = parts_out[0];
    assign m_heat_partial     = parts_out[1];
    assign m_light_partial    = parts_out[2];
    assign m_humidity_partial = parts_out[3];

`include "plant_stress_score_assert.svh"

    `PSS_ASSERT(a_ready, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready mismatch")
    `PSS_ASSERT(a_unknown, aclk, aresetn, (m_valid && !m_score_known) |-> (m_stress_score == 7'd0 && m_evaluated_mask == 4'd0 && m_soil_partial == 7'd0 && m_heat_partial == 7'd0), "unknown word not cleared")
    `PSS_ASSERT(a_range, aclk, aresetn, m_valid |-> (m_stress_score <= 7'd100 && m_soil_partial <= 7'd100 && m_heat_partial <= 7'd100 && m_light_partial <= 7'd100 && m_humidity_partial <= 7'd100), "score out of range")
    `PSS_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_valid, "valid after reset")

endmodule
`default_nettype wire
